### rtl/core/bfw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfw_pkg: shared types and codes for the byte FIFO with word port
// Field widths, action codes and the command and result records passed
// between the channel logic and the sequencer.
// ----------------------------------------------------------------------------
package bfw_pkg;

    // field widths of the channels
    localparam int ACTION_W = 3;
    localparam int DATA_W   = 16;
    localparam int BCNT_W   = 2;
    localparam int AMT_W    = 7;
    localparam int FILL_W   = 7;
    localparam int BYTE_W   = 8;

    // largest burst read in bytes
    localparam int BURST_MAX = 64;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_PUSH_BYTE = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_POP_BYTE  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK      = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PUSH_WORD = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_POP_WORD  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_BURST     = 3'd5;

    // one command as accepted
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [DATA_W-1:0]   data_in;
        logic [BCNT_W-1:0]   byte_count;
        logic [AMT_W-1:0]    amount;
    } bfw_cmd_t;

    // one result record
    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic              ok;
        logic              overrun;
        logic [FILL_W-1:0] fill_level;
        logic              last;
    } bfw_res_t;

endpackage

### rtl/core/bfw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfw_if: command and result channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface bfw_req_if;
    import bfw_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [DATA_W-1:0]   data_in;
    logic [BCNT_W-1:0]   byte_count;
    logic [AMT_W-1:0]    amount;

    modport source (output valid, output action, output data_in, output byte_count,
                    output amount, input ready);
    modport sink   (input valid, input action, input data_in, input byte_count,
                    input amount, output ready);
endinterface

interface bfw_rsp_if;
    import bfw_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    logic              ok;
    logic              overrun;
    logic [FILL_W-1:0] fill_level;
    logic              last;

    modport source (output valid, output data_out, output ok, output overrun,
                    output fill_level, output last, input ready);
    modport sink   (input valid, input data_out, input ok, input overrun,
                    input fill_level, input last, output ready);
endinterface

### rtl/core/bfw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfw_ram: byte store
// One write port and one read port with registered read data.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module bfw_ram #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [7:0]               rd_data
);
    logic [7:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end
endmodule

### rtl/core/bfw_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfw_seq: byte step sequencer
// Decodes one command and walks it byte by byte through the store port,
// keeping the pointers and the fill count.
// ----------------------------------------------------------------------------
module bfw_seq #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  bfw_pkg::bfw_cmd_t        cmd,
    output logic                     wr_en,
    output logic [$clog2(DEPTH)-1:0] wr_addr,
    output logic [7:0]               wr_data,
    output logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic [7:0]               rd_data,
    output logic                     res_valid,
    input  logic                     res_ready,
    output bfw_pkg::bfw_res_t        res
);
    import bfw_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > AMT_W) ? CNT_W : AMT_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_TAKE = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    logic [BCNT_W-1:0]   cnt_reg, cnt_next;
    logic [AMT_W-1:0]    amt_reg, amt_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [AMT_W-1:0]    rem_reg, rem_next;
    logic                sel_reg, sel_next;
    logic                drop_reg, drop_next;
    logic [DATA_W-1:0]   word_reg, word_next;
    logic                ok_reg, ok_next;
    logic                ovr_reg, ovr_next;

    logic full;
    logic empty;

    assign full  = (fill_reg == CNT_W'(DEPTH));
    assign empty = (fill_reg == '0);

    // store port addressing
    assign wr_addr = wr_ptr_reg;
    assign wr_data = sel_reg ? data_reg[15:8] : data_reg[7:0];
    assign rd_addr = rd_ptr_reg;
    assign cmd_ready = (state_reg == S_IDLE);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        data_next   = data_reg;
        cnt_next    = cnt_reg;
        amt_next    = amt_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        rem_next    = rem_reg;
        sel_next    = sel_reg;
        drop_next   = drop_reg;
        word_next   = word_reg;
        ok_next     = ok_reg;
        ovr_next    = ovr_reg;
        wr_en       = 1'b0;
        res_valid   = 1'b0;
        res.data_out   = word_reg;
        res.ok         = ok_reg;
        res.overrun    = ovr_reg;
        res.fill_level = FILL_W'(fill_reg);
        res.last       = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    act_next  = cmd.action;
                    data_next = cmd.data_in;
                    // a count of three saturates to two
                    cnt_next  = (cmd.byte_count == 2'd3) ? 2'd2 : cmd.byte_count;
                    amt_next  = cmd.amount;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                word_next  = '0;
                ok_next    = 1'b0;
                ovr_next   = 1'b0;
                sel_next   = 1'b0;
                drop_next  = 1'b0;
                state_next = S_RESP;
                case (act_reg)
                    ACT_PUSH_BYTE:
                    begin
                        rem_next   = AMT_W'(1);
                        state_next = S_WR;
                    end
                    ACT_PUSH_WORD:
                    begin
                        rem_next   = AMT_W'(cnt_reg);
                        state_next = S_WR;
                    end
                    ACT_POP_BYTE:
                    begin
                        if (!empty)
                        begin
                            fill_next  = fill_reg - CNT_W'(1);
                            rem_next   = AMT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    ACT_PEEK:
                    begin
                        if (!empty)
                        begin
                            rem_next   = AMT_W'(1);
                            state_next = S_RD;
                        end
                    end
                    ACT_POP_WORD:
                    begin
                        if (CMP_W'(cnt_reg) > CMP_W'(fill_reg))
                        begin
                            ok_next = 1'b0;
                        end
                        else if (cnt_reg == '0)
                        begin
                            ok_next = 1'b1;
                        end
                        else
                        begin
                            fill_next  = fill_reg - CNT_W'(cnt_reg);
                            rem_next   = AMT_W'(cnt_reg);
                            state_next = S_RD;
                        end
                    end
                    ACT_BURST:
                    begin
                        if ((CMP_W'(amt_reg) > CMP_W'(fill_reg)) ||
                            (amt_reg > AMT_W'(BURST_MAX)))
                        begin
                            ok_next = 1'b0;
                        end
                        else if (amt_reg == '0)
                        begin
                            ok_next = 1'b1;
                        end
                        else
                        begin
                            // fill drops by the whole burst up front
                            fill_next  = fill_reg - CNT_W'(amt_reg);
                            rem_next   = amt_reg;
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end

            // one byte written per cycle; bytes that do not fit are dropped
            S_WR:
            begin
                if (rem_reg == '0)
                begin
                    ok_next    = !drop_reg;
                    ovr_next   = drop_reg && (act_reg == ACT_PUSH_WORD);
                    state_next = S_RESP;
                end
                else
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_ptr_next = wr_ptr_reg + PTR_W'(1);
                        fill_next   = fill_reg + CNT_W'(1);
                    end
                    sel_next = !sel_reg;
                    rem_next = rem_reg - AMT_W'(1);
                end
            end

            // read data from the registered store port is ready in the cycle after the pointer
            S_RD:
            begin
                state_next = S_TAKE;
            end

            S_TAKE:
            begin
                if (act_reg == ACT_BURST)
                begin
                    res_valid      = 1'b1;
                    res.data_out   = DATA_W'(rd_data);
                    res.ok         = 1'b1;
                    res.overrun    = 1'b0;
                    res.last       = (rem_reg == AMT_W'(1));
                    if (res_ready)
                    begin
                        rd_ptr_next = rd_ptr_reg + PTR_W'(1);
                        rem_next    = rem_reg - AMT_W'(1);
                        state_next  = (rem_reg == AMT_W'(1)) ? S_IDLE : S_RD;
                    end
                end
                else
                begin
                    if (sel_reg)
                    begin
                        word_next[15:8] = rd_data;
                    end
                    else
                    begin
                        word_next[7:0] = rd_data;
                    end
                    if (act_reg != ACT_PEEK)
                    begin
                        rd_ptr_next = rd_ptr_reg + PTR_W'(1);
                    end
                    sel_next = !sel_reg;
                    rem_next = rem_reg - AMT_W'(1);
                    if (rem_reg == AMT_W'(1))
                    begin
                        ok_next    = 1'b1;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end

            S_RESP:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
            rem_reg    <= '0;
            sel_reg    <= 1'b0;
            drop_reg   <= 1'b0;
            ok_reg     <= 1'b0;
            ovr_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
            rem_reg    <= rem_next;
            sel_reg    <= sel_next;
            drop_reg   <= drop_next;
            ok_reg     <= ok_next;
            ovr_reg    <= ovr_next;
        end
    end

    // command and word payload
    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        data_reg <= data_next;
        cnt_reg  <= cnt_next;
        amt_reg  <= amt_next;
        word_reg <= word_next;
    end
endmodule

### rtl/core/byte_fifo_with_word_port_core.sv
`timescale 1ns / 1ps
// Flow: S_IDLE takes a command, S_EXEC decodes it, S_WR writes pushed bytes, S_RD and
// S_TAKE fetch read bytes, S_RESP hands the result on; a refused or zero-length read
// or a spare code goes from S_EXEC straight to S_RESP. One command is taken at a time;
// burst bytes leave S_TAKE one by one, paced by the single store read port, its
// registered read data and the result stage. Reset: pointers, fill count and handshake
// state clear at once; store contents are undefined until written and are not cleared.
// ----------------------------------------------------------------------------
// byte_fifo_with_word_port_core: circular byte FIFO with a 16-bit word port
// Byte push, pop, peek, word push/pop and all-or-nothing burst read over a
// power-of-two byte store, with a registered result stage.
// ----------------------------------------------------------------------------
module byte_fifo_with_word_port_core #(
    parameter int DEPTH = 64
) (
    input logic      clk,
    input logic      rst_n,
    bfw_req_if.sink  req,
    bfw_rsp_if.source rsp
);
    import bfw_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    bfw_cmd_t         cmd;
    bfw_res_t         res;
    logic             cmd_ready;
    logic             res_valid;
    logic             res_ready;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic [PTR_W-1:0] rd_addr;
    logic [7:0]       rd_data;

    logic             out_valid_reg, out_valid_next;
    bfw_res_t         out_res_reg, out_res_next;

    // command channel
    assign cmd.action     = req.action;
    assign cmd.data_in    = req.data_in;
    assign cmd.byte_count = req.byte_count;
    assign cmd.amount     = req.amount;
    assign req.ready      = cmd_ready;

    bfw_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bfw_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (req.valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // result register: takes a new result when empty or being drained
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    // result channel
    assign rsp.valid      = out_valid_reg;
    assign rsp.data_out   = out_res_reg.data_out;
    assign rsp.ok         = out_res_reg.ok;
    assign rsp.overrun    = out_res_reg.overrun;
    assign rsp.fill_level = out_res_reg.fill_level;
    assign rsp.last       = out_res_reg.last;
endmodule
